FILE: rtl/lnf_pkg.sv
// lnf_pkg: shared constants, types and sizes for the layer normalization unit.
// No dependencies.
`default_nettype none
package lnf_pkg;
    localparam int MAX_ROW   = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int ENTRY_W   = 48;
    localparam int EPS_W     = 17;
    localparam int RSTD_W    = 24;
    localparam logic [RSTD_W-1:0] RSTD_MAX = '1;

    typedef enum logic [0:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_EPSILON    = 1'b1
    } cfg_reg_t;

    typedef enum logic [9:0] {
        ST_LOAD  = 10'b0000000001,
        ST_SUM   = 10'b0000000010,
        ST_MEAN  = 10'b0000000100,
        ST_VAR   = 10'b0000001000,
        ST_DIV   = 10'b0000010000,
        ST_SQRT  = 10'b0000100000,
        ST_RD    = 10'b0001000000,
        ST_MUL1  = 10'b0010000000,
        ST_MUL2  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/layer_norm_forward_unit.sv
// Layer normalization top level: row store, sequencer and shared datapath.
// Depends on lnf_pkg and lnf_ram.
//
// Layer normalization over a row of up to 64 Q8.8 samples. Each input
// transaction stores one (sample, gain, offset) element. On the element
// that completes the row (count reaches row_length) the block stops
// accepting and runs: a sum pass, a 24-step restoring mean divide with
// bias removal, a squared-deviation pass, a 57-step restoring divide for
// 2^50*n/(sq+eps*n), a 27-step integer square root with rounding, then
// per element a RAM read, two registered multiplies and one output
// transaction, waiting in ST_RD while a held result stalls on m_ready.
// Results carry the row mean and rstd; the final result sets last_of_row.
// row_length 0 acts as 1, above 64 as 64; epsilon 0 acts as 1. Config
// writes are taken at any time; write only when idle.
`default_nettype none
module layer_norm_forward_unit
    import lnf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [EPS_W-1:0]   cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_sample,
    input  wire logic signed [15:0] s_gain,
    input  wire logic signed [15:0] s_offset,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_normalized,
    output logic signed [15:0]      m_row_mean,
    output logic [RSTD_W-1:0]       m_row_rstd,
    output logic                    m_last_of_row
);
    // configuration
    logic [CNT_W-1:0] row_length_reg;
    logic [EPS_W-1:0] epsilon_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= CNT_W'(MAX_ROW);
            epsilon_reg    <= EPS_W'(1);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_LENGTH: row_length_reg <= cfg_data[CNT_W-1:0];
                REG_EPSILON:    epsilon_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] len_eff;
    logic [EPS_W-1:0] eps_eff;
    always_comb begin
        len_eff = row_length_reg;
        if (len_eff == '0) len_eff = CNT_W'(1);
        if (len_eff > CNT_W'(MAX_ROW)) len_eff = CNT_W'(MAX_ROW);
        eps_eff = (epsilon_reg == '0) ? EPS_W'(1) : epsilon_reg;
    end

    state_t state_reg;
    logic [CNT_W-1:0] count_reg;   // elements stored / n
    logic [CNT_W-1:0] ptr_reg;     // pass pointer
    logic             rd_valid_reg;

    // RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [IDX_W-1:0]   wr_idx;
    assign wr_idx = (count_reg >= CNT_W'(MAX_ROW)) ? IDX_W'(MAX_ROW - 1) : count_reg[IDX_W-1:0];
    assign s_ready = (state_reg == ST_LOAD);
    assign ram_we  = s_valid && s_ready;
    assign ram_raddr = ptr_reg[IDX_W-1:0];

    lnf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ROW)) u_row_ram (
        .aclk(aclk), .we(ram_we), .waddr(wr_idx),
        .wdata({s_offset, s_gain, s_sample}),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic signed [15:0] rd_sample, rd_gain, rd_offset;
    assign rd_sample = ram_rdata[15:0];
    assign rd_gain   = ram_rdata[31:16];
    assign rd_offset = ram_rdata[47:32];

    // datapath registers
    logic signed [22:0] sum_reg;
    logic signed [15:0] mean_reg;
    logic [38:0]        sq_reg;
    logic [56:0]        num_reg;   // dividend shifting out
    logic [57:0]        rem_reg;   // remainder
    logic [56:0]        den_reg;
    logic [56:0]        quo_reg;
    logic [5:0]         step_reg;
    logic               div_mean_reg;  // divide serves the mean
    logic [51:0]        sx_reg;        // sqrt operand
    logic [52:0]        sres_reg;      // holds bit-sized values mid-root
    logic [53:0]        sbit_reg;
    logic [RSTD_W-1:0]  rstd_reg;
    logic signed [40:0] p1_reg;        // (s-mean)*rstd
    logic signed [15:0] g_reg, b_reg;
    logic signed [56:0] p2_reg;
    logic               last_reg;

    // shared restoring divider step
    logic [57:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {rem_reg[56:0], num_reg[56]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    // mean dividend 2*sum + n + 2n*2^15, never negative; quotient is mean + 2^15
    logic signed [24:0] mean_dividend;
    assign mean_dividend = 25'(sum_reg) * 25'sd2 + $signed({18'd0, count_reg})
                           + $signed({2'b0, count_reg, 16'd0});

    logic signed [16:0] dev;
    logic signed [33:0] dev_wide;
    logic [33:0]        dev_sq;
    assign dev      = 17'(rd_sample) - 17'(mean_reg);
    assign dev_wide = 34'(dev);
    assign dev_sq   = dev_wide * dev_wide;

    logic [53:0] s_trial;
    assign s_trial = 54'(sres_reg) + sbit_reg;

    // output rounding
    logic signed [56:0] y_full;
    logic signed [32:0] y_sh;
    logic signed [33:0] y_sum;
    assign y_full = p2_reg + 57'sd8388608;
    assign y_sh   = 33'(y_full >>> 24);
    assign y_sum  = 34'(y_sh) + 34'(b_reg);

    logic [25:0] rstd_rnd;
    assign rstd_rnd = 26'((54'(sres_reg) + 54'd1) >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            m_valid      <= 1'b0;
            rd_valid_reg <= 1'b0;
            ptr_reg      <= '0;
        end else begin
            case (state_reg)
                ST_LOAD: if (ram_we) begin
                    if (CNT_W'(wr_idx) + CNT_W'(1) >= len_eff) begin
                        count_reg <= CNT_W'(wr_idx) + CNT_W'(1);
                        ptr_reg   <= '0;
                        sum_reg   <= '0;
                        rd_valid_reg <= 1'b0;
                        state_reg <= ST_SUM;
                    end else begin
                        count_reg <= CNT_W'(wr_idx) + CNT_W'(1);
                    end
                end
                ST_SUM, ST_VAR: begin
                    // read issued at ptr, consumed in the next cycle
                    rd_valid_reg <= (ptr_reg < count_reg);
                    if (ptr_reg < count_reg) ptr_reg <= ptr_reg + CNT_W'(1);
                    if (rd_valid_reg) begin
                        if (state_reg == ST_SUM) sum_reg <= sum_reg + 23'(rd_sample);
                        else sq_reg <= sq_reg + 39'(dev_sq);
                    end
                    if (!rd_valid_reg && ptr_reg == count_reg && ptr_reg != '0) begin
                        ptr_reg <= '0;
                        if (state_reg == ST_SUM) begin
                            // mean = floor((2sum+n)/(2n)), biased by 2^15
                            num_reg  <= {mean_dividend[23:0], 33'd0};
                            den_reg  <= 57'(count_reg) << 1;
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            step_reg <= 6'd23;
                            div_mean_reg <= 1'b1;
                            state_reg <= ST_DIV;
                        end else begin
                            num_reg  <= 57'(count_reg) << 50;
                            den_reg  <= 57'(sq_reg) + 57'(eps_eff) * 57'(count_reg);
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            step_reg <= 6'd57 - 6'd1;
                            div_mean_reg <= 1'b0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    num_reg <= num_reg << 1;
                    rem_reg <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                    quo_reg <= {quo_reg[55:0], rem_ge};
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0) state_reg <= ST_MEAN;
                end
                ST_MEAN: begin
                    if (div_mean_reg) begin
                        // remove the 2^15 bias
                        mean_reg <= {~quo_reg[15], quo_reg[14:0]};
                        sq_reg   <= '0;
                        ptr_reg  <= '0;
                        rd_valid_reg <= 1'b0;
                        state_reg <= ST_VAR;
                    end else begin
                        sx_reg   <= quo_reg[51:0];
                        sres_reg <= '0;
                        sbit_reg <= 54'd1 << 52;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sbit_reg == '0) begin
                        rstd_reg <= (rstd_rnd > 26'(RSTD_MAX)) ? RSTD_MAX : rstd_rnd[23:0];
                        ptr_reg  <= '0;
                        state_reg <= ST_RD;
                    end else begin
                        if (54'(sx_reg) >= s_trial) begin
                            sx_reg   <= 52'(54'(sx_reg) - s_trial);
                            sres_reg <= 53'((54'(sres_reg) >> 1) + sbit_reg);
                        end else begin
                            sres_reg <= sres_reg >> 1;
                        end
                        sbit_reg <= sbit_reg >> 2;
                    end
                end
                ST_RD: if (!m_valid || m_ready) begin
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    p1_reg <= 41'(dev) * $signed({1'b0, rstd_reg});
                    g_reg  <= rd_gain;
                    b_reg  <= rd_offset;
                    last_reg <= (ptr_reg + CNT_W'(1) == count_reg);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    p2_reg <= 57'(p1_reg) * 57'(g_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    m_normalized <= (y_sum > 34'sd32767) ? 16'sd32767 :
                                    (y_sum < -34'sd32768) ? -16'sd32768 : 16'(y_sum);
                    m_row_mean    <= mean_reg;
                    m_row_rstd    <= rstd_reg;
                    m_last_of_row <= last_reg;
                    if (last_reg) begin
                        count_reg <= '0;
                        state_reg <= ST_LOAD;
                    end else begin
                        ptr_reg   <= ptr_reg + CNT_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
            // a held result drops on acceptance in any state
            if (state_reg == ST_OUT) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lnf_ram.sv
// lnf_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`default_nettype none
module lnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

FILE: tb/layer_norm_forward_checker.sv
// Scoreboard for layer_norm_forward_unit: watches config, input and result channels,
// predicts each row's results and compares them in order. Depends on lnf_pkg.
`default_nettype none
module layer_norm_forward_checker
    import lnf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [EPS_W-1:0]   cfg_data,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic signed [15:0] s_sample,
    input  wire logic signed [15:0] s_gain,
    input  wire logic signed [15:0] s_offset,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [15:0] m_normalized,
    input  wire logic signed [15:0] m_row_mean,
    input  wire logic [RSTD_W-1:0]  m_row_rstd,
    input  wire logic               m_last_of_row,
    output int                      fail_count,
    output int                      pending,
    output int                      results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] norm;
        logic signed [15:0] mean;
        logic [RSTD_W-1:0]  rstd;
        logic               last;
    } ln_result_t;

    ln_result_t         expected_results[$];
    logic [6:0]         len_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic signed [15:0] row_sample[MAX_ROW];
    logic signed [15:0] row_gain[MAX_ROW];
    logic signed [15:0] row_offset[MAX_ROW];
    int                 stored;

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Store one element; on row completion queue every normalized result.
    task automatic store_and_normalize(logic signed [15:0] smp, logic signed [15:0] gn,
                                       logic signed [15:0] off);
        int              eff_len;
        int              slot;
        int              n;
        longint          sum;
        longint          num;
        longint          den;
        longint          mean;
        longint          dev;
        longint          prod;
        longint          y;
        longint unsigned sq;
        longint unsigned eps;
        longint unsigned quot;
        longint unsigned rstd;
        ln_result_t      r;
        eff_len = (len_reg == 0) ? 1 : (len_reg > MAX_ROW) ? MAX_ROW : int'(len_reg);
        eps = (eps_reg == 0) ? 1 : eps_reg;
        slot = (stored >= MAX_ROW) ? MAX_ROW - 1 : stored;
        row_sample[slot] = smp;
        row_gain[slot] = gn;
        row_offset[slot] = off;
        n = slot + 1;
        stored = n;
        if (n < eff_len) return;
        stored = 0;
        sum = 0;
        for (int i = 0; i < n; i++) sum += row_sample[i];
        // mean rounded half up: floor((2*sum + n) / 2n)
        num = 2 * sum + n;
        den = 2 * n;
        mean = num / den;
        if ((num % den) != 0 && num < 0) mean--;
        sq = 0;
        for (int i = 0; i < n; i++) begin
            dev = row_sample[i] - mean;
            sq += longint'(dev * dev);
        end
        quot = ((64'd1 << 50) * n) / (sq + eps * n);
        rstd = (floor_sqrt(quot) + 1) >> 1;
        if (rstd > RSTD_MAX) rstd = RSTD_MAX;
        for (int i = 0; i < n; i++) begin
            prod = (row_sample[i] - mean) * longint'(rstd) * row_gain[i];
            y = ((prod + (64'sd1 <<< 23)) >>> 24) + row_offset[i];
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            r.norm = y[15:0];
            r.mean = mean[15:0];
            r.rstd = rstd[RSTD_W-1:0];
            r.last = (i + 1 == n);
            expected_results.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        ln_result_t e;
        if (!aresetn) begin
            len_reg <= 7'd64;
            eps_reg <= 1;
            stored = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ROW_LENGTH) len_reg <= cfg_data[6:0];
                else eps_reg <= cfg_data;
            end
            if (s_valid && s_ready) store_and_normalize(s_sample, s_gain, s_offset);
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result norm=%0d mean=%0d rstd=%0d last=%0b",
                                 m_normalized, m_row_mean, m_row_rstd, m_last_of_row);
                end else begin
                    e = expected_results.pop_front();
                    if (e.norm !== m_normalized || e.mean !== m_row_mean ||
                        e.rstd !== m_row_rstd || e.last !== m_last_of_row) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: result %0d exp norm=%0d mean=%0d rstd=%0d last=%0b",
                                      " got norm=%0d mean=%0d rstd=%0d last=%0b"},
                                     results_checked, e.norm, e.mean, e.rstd, e.last,
                                     m_normalized, m_row_mean, m_row_rstd, m_last_of_row);
                    end
                end
            end
        end
        pending <= expected_results.size();
    end

    initial begin
        fail_count = 0;
        results_checked = 0;
        pending = 0;
        stored = 0;
        len_reg = 7'd64;
        eps_reg = 1;
    end
endmodule
`default_nettype wire

FILE: tb/layer_norm_forward_unit_tb.sv
// Top of the layer_norm_forward_unit testbench: clock, reset, stimulus and verdict.
// Depends on lnf_pkg, layer_norm_forward_unit and layer_norm_forward_checker.
`default_nettype none
module layer_norm_forward_unit_tb;
    import lnf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 200;   // covers root, divides and a short row

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index = '0;
    logic [EPS_W-1:0]   cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample = '0;
    logic signed [15:0] s_gain = '0;
    logic signed [15:0] s_offset = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_normalized;
    logic signed [15:0] m_row_mean;
    logic [RSTD_W-1:0]  m_row_rstd;
    logic               m_last_of_row;

    int fail_count;
    int pending;
    int results_checked;
    int send_idle_pct = 0;     // percent chance the sender idles before an element
    int recv_stall_pct = 0;    // percent chance m_ready is drawn low
    int samples_sent = 0;
    int rows_sent = 0;
    int cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    layer_norm_forward_unit uut (.*);

    layer_norm_forward_checker chk (.*);

    // Result-side back pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("layer_norm_forward_unit test failed");
            $finish;
        end
    end

    // Register write; only issued while the block has nothing in flight.
    task automatic write_reg(cfg_reg_t idx, logic [EPS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One input transaction. Valid stays high across back-to-back transactions;
    // within this task it only drops when the sender decides to idle.
    task automatic send_element(logic signed [15:0] smp, logic signed [15:0] gn,
                                logic signed [15:0] off);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_gain   <= gn;
        s_offset <= off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // One full row of n elements with content shaped by a random style:
    // full-range noise, a tight cluster (large rstd), or a flat row (zero variance).
    task automatic send_row(int n);
        int   style;
        int   center;
        int   spread;
        logic signed [15:0] smp;
        style = $urandom_range(3);
        center = $urandom_range(65535) - 32768;
        spread = 1 << $urandom_range(12);
        for (int i = 0; i < n; i++) begin
            case (style)
                0, 1: begin
                    smp = 16'($urandom());
                end
                2: begin
                    smp = 16'(center + int'($urandom_range(2 * spread)) - spread);
                end
                default: begin
                    smp = 16'(center);
                end
            endcase
            send_element(smp, 16'($urandom()), 16'($urandom()));
        end
        rows_sent++;
    endtask

    // A random phase of rows; mostly short rows, row length and epsilon redrawn
    // between rows, including the out-of-range encodings.
    task automatic random_phase(int target, bit force_long);
        int start;
        int len_code;
        int eff;
        logic [EPS_W-1:0] eps;
        start = samples_sent;
        if (force_long) begin
            write_reg(REG_ROW_LENGTH, 17'd127);   // clamps to a full 64-element row
            send_row(MAX_ROW);
            drain();
        end
        while (samples_sent - start < target) begin
            case ($urandom_range(9))
                0: len_code = 0;
                1: len_code = $urandom_range(127, 65);
                2: len_code = $urandom_range(24, 9);
                default: len_code = $urandom_range(8, 1);
            endcase
            case ($urandom_range(4))
                0: eps = 0;
                1: eps = 17'h1FFFF;
                2: eps = 17'd65536;
                default: eps = 17'($urandom_range(4096, 1));
            endcase
            eff = (len_code == 0) ? 1 : (len_code > MAX_ROW) ? MAX_ROW : len_code;
            // full rows are costly; keep them rare
            if (eff == MAX_ROW && $urandom_range(3) != 0) begin
                len_code = 4;
                eff = 4;
            end
            write_reg(REG_ROW_LENGTH, 17'(len_code));
            write_reg(REG_EPSILON, eps);
            send_row(eff);
            drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-element rows at the field extremes, epsilon 65536.
        write_reg(REG_ROW_LENGTH, 17'd1);
        write_reg(REG_EPSILON, 17'd65536);
        send_element(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_element(-16'sh8000, -16'sh8000, -16'sh8000);
        drain();

        // Zero row length and zero epsilon both act as one.
        write_reg(REG_ROW_LENGTH, 17'd0);
        write_reg(REG_EPSILON, 17'd0);
        send_element(16'sh1234, -16'sh8000, 16'sh0001);
        send_element(-16'sh0001, 16'sh7FFF, -16'sh0001);
        drain();

        // Two-element rows: max spread with saturating output, then a flat row
        // where rstd saturates, then all-ones epsilon.
        write_reg(REG_ROW_LENGTH, 17'd2);
        write_reg(REG_EPSILON, 17'd1);
        send_element(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_element(-16'sh8000, 16'sh7FFF, -16'sh8000);
        drain();
        send_element(16'sh0100, 16'sh0100, 16'sh0000);
        send_element(16'sh0100, -16'sh8000, 16'sh0000);
        drain();
        write_reg(REG_EPSILON, 17'h1FFFF);
        send_element(16'sh0003, -16'sh8000, 16'sh7FFF);
        send_element(-16'sh0004, 16'sh7FFF, -16'sh8000);
        drain();

        // Row length lowered mid-row: five elements held, length dropped to
        // three, the next element closes a six-element row.
        write_reg(REG_ROW_LENGTH, 17'd8);
        write_reg(REG_EPSILON, 17'd256);
        for (int i = 0; i < 5; i++)
            send_element(16'($urandom()), 16'($urandom()), 16'($urandom()));
        drain();
        write_reg(REG_ROW_LENGTH, 17'd3);
        send_element(16'sh5555, -16'sh2AAB, 16'sh00FF);
        drain();

        // Random phases under different idling patterns.
        send_idle_pct = 0;  recv_stall_pct = 0;
        random_phase(25, 1'b0);
        send_idle_pct = 49; recv_stall_pct = 0;
        random_phase(25, 1'b0);
        send_idle_pct = 0;  recv_stall_pct = 49;
        random_phase(10, 1'b1);
        send_idle_pct = 16; recv_stall_pct = 16;
        random_phase(20, 1'b0);

        drain();
        $display("covered %0d input transactions in %0d rows, %0d results checked",
                 samples_sent, rows_sent + 8, results_checked);
        $display("row lengths 0..127 incl. clamping, epsilon 0..131071, mid-row length drop");
        if (fail_count == 0) begin
            $display("layer_norm_forward_unit test passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("layer_norm_forward_unit test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: layer_norm_forward_unit.f
rtl/lnf_pkg.sv
rtl/lnf_ram.sv
rtl/layer_norm_forward_unit.sv
tb/layer_norm_forward_checker.sv
tb/layer_norm_forward_unit_tb.sv
